>>> design/orq_pkg.sv
// Shared types and constants for the ordered record queue.
// No dependencies; every other design file imports this package.
`default_nettype none
package orq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_INSERT_AT = 3'd2,
        OP_POP_HEAD  = 3'd3,
        OP_FIND_ID   = 3'd4,
        OP_FIND_SPD  = 3'd5,
        OP_FIND_PRI  = 3'd6,
        OP_FIND_TIME = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [4:0]         slot;
        logic [31:0]        car_id;
        logic signed [15:0] car_kind;
        logic signed [15:0] car_speed;
        logic signed [15:0] car_priority;
        logic [31:0]        deadline;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         found_index;
        logic [31:0]        out_id;
        logic signed [15:0] out_kind;
        logic signed [15:0] out_speed;
        logic signed [15:0] out_priority;
        logic [31:0]        out_deadline;
    } rsp_t;

    typedef struct packed {
        logic [31:0]        id;
        logic signed [15:0] kind;
        logic signed [15:0] speed;
        logic signed [15:0] prio;
        logic [31:0]        deadline;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SEARCH,
        S_RESPOND
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;
        logic rd_en;
        logic shift_up;
        logic shift_down;
        logic write_new;
        logic search;
        logic cnt_inc;
        logic cnt_dec;
        logic pop_capture;
        logic finish;
        logic set_full;
        logic set_empty;
    } ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_pos;
        logic at_end;
        logic hit;
    } sts_t;

endpackage
`default_nettype wire

>>> design/orq_ctrl.sv
// Controller state machine of the ordered record queue.
// Depends on orq_pkg for the state, command and status types.
`default_nettype none
module orq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire orq_pkg::op_t  op,
    input  wire orq_pkg::sts_t sts,
    input  wire logic          rsp_free,
    output orq_pkg::ctl_t      ctl,
    output logic               in_ready
);
    import orq_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_APPEND;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE) && rsp_free;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = op;
                    if (op inside {OP_APPEND, OP_PUSH_HEAD, OP_INSERT_AT})
                        state_next = sts.full ? S_RESPOND : S_SHIFT_UP;
                    else if (op == OP_POP_HEAD)
                        state_next = sts.empty ? S_RESPOND : S_SHIFT_DOWN;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SHIFT_UP:
                if (sts.at_pos)
                    state_next = S_RESPOND;
            S_SHIFT_DOWN:
                if (sts.at_end)
                    state_next = S_RESPOND;
            S_SEARCH:
                if (sts.at_end || sts.hit)
                    state_next = S_RESPOND;
            S_RESPOND:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.load_req = 1'b1;
                    ctl.rd_en    = 1'b1;
                    if (op inside {OP_APPEND, OP_PUSH_HEAD, OP_INSERT_AT})
                        ctl.set_full = sts.full;
                    else if (op == OP_POP_HEAD)
                    begin
                        ctl.set_empty   = sts.empty;
                        ctl.pop_capture = !sts.empty;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                ctl.rd_en = 1'b1;
                if (sts.at_pos)
                begin
                    ctl.write_new = 1'b1;
                    ctl.cnt_inc   = 1'b1;
                end
                else
                    ctl.shift_up = 1'b1;
            end
            S_SHIFT_DOWN:
            begin
                ctl.rd_en = 1'b1;
                if (sts.at_end)
                    ctl.cnt_dec = 1'b1;
                else
                    ctl.shift_down = 1'b1;
            end
            S_SEARCH:
            begin
                ctl.rd_en  = 1'b1;
                ctl.search = 1'b1;
            end
            S_RESPOND:
                ctl.finish = 1'b1;
            default:
                ctl = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> design/orq_datapath.sv
// Datapath of the ordered record queue: record memory, count, walk pointer,
// comparators and the result register. Depends on orq_pkg.
`default_nettype none
module orq_datapath #(
    parameter int QUEUE_DEPTH = orq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire orq_pkg::req_t in_req,
    input  wire orq_pkg::ctl_t ctl,
    output orq_pkg::sts_t      sts,
    output orq_pkg::rsp_t      rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output logic               rsp_free
);
    import orq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    rec_t          mem [QUEUE_DEPTH];
    rec_t          rd_data_reg;
    req_t          req_reg, req_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    rsp_t          rsp_reg, rsp_next;
    rsp_t          work_reg, work_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    logic          wr_en;
    rec_t          wr_data;
    rec_t          new_rec;
    logic          match;
    logic [CW-1:0] ins_pos;

    assign new_rec = '{id: req_reg.car_id, kind: req_reg.car_kind,
                       speed: req_reg.car_speed, prio: req_reg.car_priority,
                       deadline: req_reg.deadline};

    always_comb
    begin
        ins_pos = count_reg;
        if (in_req.op == OP_PUSH_HEAD)
            ins_pos = '0;
        else if (in_req.op == OP_INSERT_AT && CW'(in_req.slot) < count_reg
                 && {{(CW > 5 ? CW - 5 : 0){1'b0}}, in_req.slot} == CW'(in_req.slot))
            ins_pos = CW'(in_req.slot);
    end

    // Walk pointer and read address for each kind of pass.
    always_comb
    begin
        rd_addr = ptr_reg;
        if (ctl.load_req)
        begin
            if (in_req.op inside {OP_APPEND, OP_PUSH_HEAD, OP_INSERT_AT})
                rd_addr = count_reg - CW'(1);
            else if (in_req.op == OP_POP_HEAD)
                rd_addr = CW'(1);
            else
                rd_addr = '0;
        end
        else if (ctl.shift_up)
            rd_addr = ptr_reg - CW'(2);
        else if (ctl.shift_down)
            rd_addr = ptr_reg + CW'(2);
        else if (ctl.search)
            rd_addr = ptr_reg + CW'(1);
    end

    always_comb
    begin
        case (req_reg.op)
            OP_FIND_ID:   match = rd_data_reg.id == req_reg.car_id;
            OP_FIND_SPD:  match = rd_data_reg.speed <= req_reg.car_speed;
            OP_FIND_PRI:  match = rd_data_reg.prio >= req_reg.car_priority;
            OP_FIND_TIME: match = rd_data_reg.deadline >= req_reg.deadline;
            default:      match = 1'b0;
        endcase
    end

    always_comb
    begin
        sts.full   = count_reg >= DEPTH_C;
        sts.empty  = count_reg == '0;
        sts.at_pos = ptr_reg == pos_reg;
        if (req_reg.op == OP_POP_HEAD)
            sts.at_end = (ptr_reg + CW'(1)) >= count_reg;
        else
            sts.at_end = ptr_reg >= count_reg;
        sts.hit = (ptr_reg < count_reg) && match;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        if (ctl.shift_up)
            wr_en = 1'b1;
        else if (ctl.shift_down)
            wr_en = 1'b1;
        else if (ctl.write_new)
        begin
            wr_en   = 1'b1;
            wr_data = new_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[AW-1:0]] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    always_comb
    begin
        req_next   = req_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        first_next = first_reg;
        work_next  = work_reg;
        if (ctl.load_req)
        begin
            req_next  = in_req;
            work_next = '0;
            pos_next  = ins_pos;
            if (in_req.op inside {OP_APPEND, OP_PUSH_HEAD, OP_INSERT_AT})
                ptr_next = count_reg;
            else
                ptr_next = '0;
            if (ctl.set_full)
                work_next.status = ST_FULL;
            if (ctl.set_empty)
                work_next.status = ST_EMPTY;
        end
        if (ctl.pop_capture)
            first_next = 1'b1;
        if (first_reg && (ctl.shift_down || ctl.cnt_dec))
        begin
            first_next             = 1'b0;
            work_next.out_id       = rd_data_reg.id;
            work_next.out_kind     = rd_data_reg.kind;
            work_next.out_speed    = rd_data_reg.speed;
            work_next.out_priority = rd_data_reg.prio;
            work_next.out_deadline = rd_data_reg.deadline;
        end
        if (ctl.shift_up)
            ptr_next = ptr_reg - CW'(1);
        if (ctl.shift_down)
            ptr_next = ptr_reg + CW'(1);
        if (ctl.cnt_inc)
            count_next = count_reg + CW'(1);
        if (ctl.cnt_dec)
            count_next = count_reg - CW'(1);
        if (ctl.search)
        begin
            if (sts.hit)
                work_next.found_index = 5'(ptr_reg);
            else if (sts.at_end)
            begin
                work_next.found_index = 5'(count_reg);
                if (req_reg.op == OP_FIND_ID)
                    work_next.status = ST_NOT_FOUND;
            end
            else
                ptr_next = ptr_reg + CW'(1);
        end
    end

    // The pop pass reads entry 1 first, so the head is not among its reads.
    // The shift pass moves entry ptr+1 down into ptr, so the head read is
    // taken from the word loaded at the start.
    rec_t head_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
            head_reg <= mem[0];
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (ctl.finish)
        begin
            rsp_next       = work_reg;
            rsp_valid_next = 1'b1;
            if (req_reg.op == OP_POP_HEAD && work_reg.status == ST_OK)
            begin
                rsp_next.out_id       = head_reg.id;
                rsp_next.out_kind     = head_reg.kind;
                rsp_next.out_speed    = head_reg.speed;
                rsp_next.out_priority = head_reg.prio;
                rsp_next.out_deadline = head_reg.deadline;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        work_reg <= work_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

endmodule
`default_nettype wire

>>> design/ordered_record_queue.sv
// Top level of the ordered record queue: controller plus datapath.
// Depends on orq_pkg, orq_ctrl and orq_datapath.
//
// A bounded ordered queue of up to QUEUE_DEPTH records with append, push,
// insert, pop and four position searches. One request at a time: an insert
// walks the entries from the tail down to the insert position, one move per
// cycle through the record memory's one read and one write port; a pop moves
// every entry behind the head down once; a search reads one entry a cycle
// until a hit or the end. Full and empty cases skip the pass. The result sits
// in an output register, and the next request is taken once that register is
// free. No clearing pass follows reset.
`default_nettype none
module ordered_record_queue #(
    parameter int QUEUE_DEPTH = orq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire orq_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output orq_pkg::rsp_t      out_data
);
    import orq_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic rsp_free;

    orq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op_t'(in_data.op)),
        .sts      (sts),
        .rsp_free (rsp_free),
        .ctl      (ctl),
        .in_ready (in_ready)
    );

    orq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_data),
        .ctl       (ctl),
        .sts       (sts),
        .rsp       (out_data),
        .rsp_valid (out_valid),
        .rsp_ready (out_ready),
        .rsp_free  (rsp_free)
    );

endmodule
`default_nettype wire

>>> design/orq_checker.sv
// Port-level checker for the ordered record queue, bound to the top level.
// Depends on orq_pkg.
`default_nettype none
module orq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire orq_pkg::req_t in_data,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire orq_pkg::rsp_t out_data
);
    import orq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !(out_valid && $rose(out_valid)))
        else $error("result appeared one cycle after request");

    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.out_id == '0)
        else $error("record fields set on a failed request");

endmodule

bind ordered_record_queue orq_checker u_orq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

>>> dv/tb_ordered_record_queue.sv
// Testbench for the ordered record queue: directed and random requests, checked
// against a behavioral queue model kept in the testbench.
// Depends on orq_pkg and ordered_record_queue.
`timescale 1ns / 1ps
module tb_ordered_record_queue;
    import orq_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    rec_t model_recs[DEPTH];
    int model_count;
    rsp_t expected_rsps[$];
    int error_count;
    int idle_pct;
    int stall_pct;
    bit hold_receiver;
    int quiet_cycles;

    ordered_record_queue i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic rsp_t predict_queue(req_t req);
        rsp_t rsp;
        rec_t rec;
        int pos;
        bit hit;
        rsp = '0;
        rec.id = req.car_id;
        rec.kind = req.car_kind;
        rec.speed = req.car_speed;
        rec.prio = req.car_priority;
        rec.deadline = req.deadline;
        case (op_t'(req.op))
            OP_APPEND, OP_PUSH_HEAD, OP_INSERT_AT:
            begin
                if (model_count >= DEPTH)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    if (req.op == OP_APPEND)
                        pos = model_count;
                    else if (req.op == OP_PUSH_HEAD)
                        pos = 0;
                    else
                        pos = (req.slot < model_count) ? req.slot : model_count;
                    for (int i = model_count; i > pos; i--)
                        model_recs[i] = model_recs[i - 1];
                    model_recs[pos] = rec;
                    model_count++;
                end
            end
            OP_POP_HEAD:
            begin
                if (model_count == 0)
                begin
                    rsp.status = ST_EMPTY;
                end
                else
                begin
                    rsp.out_id = model_recs[0].id;
                    rsp.out_kind = model_recs[0].kind;
                    rsp.out_speed = model_recs[0].speed;
                    rsp.out_priority = model_recs[0].prio;
                    rsp.out_deadline = model_recs[0].deadline;
                    for (int i = 1; i < model_count; i++)
                        model_recs[i - 1] = model_recs[i];
                    model_count--;
                end
            end
            default:
            begin
                hit = 1'b0;
                pos = model_count;
                for (int i = 0; i < model_count && !hit; i++)
                begin
                    case (op_t'(req.op))
                        OP_FIND_ID:  hit = model_recs[i].id == req.car_id;
                        OP_FIND_SPD: hit = model_recs[i].speed <= req.car_speed;
                        OP_FIND_PRI: hit = model_recs[i].prio >= req.car_priority;
                        default:     hit = model_recs[i].deadline >= req.deadline;
                    endcase
                    if (hit)
                        pos = i;
                end
                if (!hit && req.op == OP_FIND_ID)
                    rsp.status = ST_NOT_FOUND;
                rsp.found_index = pos[4:0];
            end
        endcase
        return rsp;
    endfunction

    task automatic send_request(req_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_rsps.push_back(predict_queue(req));
        @(negedge clk);
    endtask

    function automatic req_t random_request(int pop_weight);
        req_t req;
        int pick;
        req.op = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < pop_weight)
            req.op = OP_POP_HEAD;
        req.slot = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
                                              5'($urandom_range(DEPTH));
        req.car_kind = 16'($urandom);
        req.car_speed = 16'($urandom);
        req.car_priority = 16'($urandom);
        req.deadline = $urandom;
        req.car_id = $urandom;
        // Reuse ids of stored records so that id searches hit.
        if (model_count > 0 && $urandom_range(1))
            req.car_id = model_recs[$urandom_range(model_count - 1)].id;
        return req;
    endfunction

    function automatic req_t make_request(op_t op, logic [4:0] slot, logic [31:0] id,
                                          logic [15:0] val, logic [31:0] dl);
        req_t req;
        req.op = op;
        req.slot = slot;
        req.car_id = id;
        req.car_kind = val;
        req.car_speed = val;
        req.car_priority = val;
        req.deadline = dl;
        return req;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_request(make_request(OP_POP_HEAD, 0, 0, 0, 0));
        send_request(make_request(OP_FIND_ID, 0, 32'hFFFF_FFFF, 0, 0));
        send_request(make_request(OP_FIND_SPD, 0, 0, 16'h8000, 0));
        send_request(make_request(OP_APPEND, 0, 32'hFFFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF));
        send_request(make_request(OP_PUSH_HEAD, 0, 0, 16'h8000, 0));
        send_request(make_request(OP_INSERT_AT, 0, 5, 16'h0001, 32'h8000_0000));
        send_request(make_request(OP_INSERT_AT, 31, 6, 16'hFFFF, 7));
        send_request(make_request(OP_INSERT_AT, 2, 7, 16'h0000, 9));
        send_request(make_request(OP_FIND_ID, 0, 7, 0, 0));
        send_request(make_request(OP_FIND_ID, 0, 99, 0, 0));
        send_request(make_request(OP_FIND_SPD, 0, 0, 16'h8000, 0));
        send_request(make_request(OP_FIND_SPD, 0, 0, 16'h7FFF, 0));
        send_request(make_request(OP_FIND_PRI, 0, 0, 16'h7FFF, 0));
        send_request(make_request(OP_FIND_PRI, 0, 0, 16'h8000, 0));
        send_request(make_request(OP_FIND_TIME, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_request(OP_FIND_TIME, 0, 0, 0, 0));
        while (model_count < DEPTH)
            send_request(make_request(OP_APPEND, 0, model_count, 16'h1234, 1));
        send_request(make_request(OP_APPEND, 0, 1, 0, 0));
        send_request(make_request(OP_PUSH_HEAD, 0, 1, 0, 0));
        send_request(make_request(OP_INSERT_AT, 3, 1, 0, 0));
        send_request(make_request(OP_FIND_TIME, 0, 0, 0, 2));
        while (model_count > 0)
            send_request(make_request(OP_POP_HEAD, 0, 0, 0, 0));
        send_request(make_request(OP_POP_HEAD, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_random(int items, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < items; n++)
            // Drift between filling and draining so both full and empty are reached.
            send_request(random_request(((n / 40) % 2) ? 35 : 5));
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_receiver = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_receiver = 1'b0;
            end
            for (int n = 0; n < 10; n++)
                send_request(random_request(10));
        join
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        out_ready <= !hold_receiver && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("Response with no request outstanding: %h", out_data);
                error_count++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (out_data.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, out_data.status);
                    error_count++;
                end
                if (out_data.found_index !== exp_rsp.found_index)
                begin
                    $error("found_index: expected %0d, got %0d", exp_rsp.found_index,
                           out_data.found_index);
                    error_count++;
                end
                if (out_data.out_id !== exp_rsp.out_id)
                begin
                    $error("out_id: expected %h, got %h", exp_rsp.out_id, out_data.out_id);
                    error_count++;
                end
                if (out_data.out_kind !== exp_rsp.out_kind)
                begin
                    $error("out_kind: expected %0d, got %0d", exp_rsp.out_kind,
                           out_data.out_kind);
                    error_count++;
                end
                if (out_data.out_speed !== exp_rsp.out_speed)
                begin
                    $error("out_speed: expected %0d, got %0d", exp_rsp.out_speed,
                           out_data.out_speed);
                    error_count++;
                end
                if (out_data.out_priority !== exp_rsp.out_priority)
                begin
                    $error("out_priority: expected %0d, got %0d", exp_rsp.out_priority,
                           out_data.out_priority);
                    error_count++;
                end
                if (out_data.out_deadline !== exp_rsp.out_deadline)
                begin
                    $error("out_deadline: expected %h, got %h", exp_rsp.out_deadline,
                           out_data.out_deadline);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        model_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(210, 0, 0);
        test_random(210, 59, 0);
        test_random(210, 0, 59);
        test_random(210, 23, 23);
        test_backpressure();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> files.f
design/orq_pkg.sv
design/orq_ctrl.sv
design/orq_datapath.sv
design/ordered_record_queue.sv
design/orq_checker.sv
dv/tb_ordered_record_queue.sv
